// ===== hw/rtl/rfpa_pkg.sv =====
// shared types and constants for the range frame parser and averager
`timescale 1ns / 1ps

package rfpa_pkg;

    // frame layout
    localparam logic [7:0]  FRAME_HEADER = 8'h5C;
    localparam logic [2:0]  FRAME_LEN    = 3'd5;
    localparam logic [23:0] INVALID_DIST = 24'h3FFFFF;

    // widths
    localparam int DIST_W  = 22;
    localparam int RAW_W   = 24;
    localparam int COUNT_W = 16;
    localparam int SUM_W   = 40;
    localparam int CNT_W   = 6;

    localparam logic [DIST_W-1:0]  DEFAULT_LIMIT_CM = 22'd130000;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

    // one quotient bit per divider step
    localparam logic [CNT_W-1:0] DIV_STEPS = 6'd40;

    // input item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_AVG  = 2'd1;
    localparam logic [1:0] STATUS_OOR  = 2'd2;

    // register indexes (paddr bit 2)
    localparam logic REG_LIMIT  = 1'b0;
    localparam logic REG_REPORT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PARSE,
        ST_TAKE,
        ST_DIV,
        ST_EMIT
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== hw/rtl/rfpa_divider.sv =====
// restoring divider, one quotient bit per cycle, for the distance average
`timescale 1ns / 1ps

module rfpa_divider
    import rfpa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SUM_W-1:0]   i_dividend,
    input  logic [COUNT_W-1:0] i_divisor,
    output t_div_stat          o_stat,
    output logic [SUM_W-1:0]   o_quotient
);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [SUM_W-1:0]   r_dvd;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_div;

    logic [COUNT_W:0]   n_rem_sh;
    logic               n_qbit;
    logic [COUNT_W:0]   n_rem_sub;

    // shift in next dividend bit and try the subtract
    always_comb begin
        n_rem_sh  = {r_rem, r_dvd[SUM_W-1]};
        n_rem_sub = n_rem_sh - {1'b0, r_div};
        n_qbit    = (n_rem_sh >= {1'b0, r_div});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_STEPS - 1'b1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, quotient bits replace dividend bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[SUM_W-2:0], n_qbit};
            r_rem <= n_qbit ? n_rem_sub[COUNT_W-1:0] : n_rem_sh[COUNT_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_dvd;

endmodule

// ===== hw/rtl/range_frame_parse_average_core.sv =====
// top level: rangefinder frame parser, averager and poll responder
`timescale 1ns / 1ps

// Input stream: s_axis_tuser selects the kind of item (0 received UART byte,
// 1 poll), s_axis_tdata carries the byte. Bytes are assembled into 5-byte
// frames (header 0x5C, three distance bytes, inverted-sum checksum); bad
// frames resync on the next buffered header. Good frames are either flagged
// out of range or summed and counted.
// Output stream: one transaction per poll, none per byte. m_axis_tuser is the
// status, m_axis_tdata holds distance and frame count.
// Timing: the sequencer works one item at a time. A byte is stored, then parse
// steps over the 5-byte buffer each drop one leading non-header byte or bad frame
// start, and a good frame takes one accumulate step. A poll with frames waits on
// the 40-step bit-serial divider; a poll without frames skips it.
// The result sits in an output register, so bytes keep flowing while the
// receiver stalls; a second poll waits until the first result is taken.
// Reset: synchronous, active low; clears the buffer fill, accumulators and
// the output valid, and loads both registers with 130000.
// Registers over APB: 0x0 distance limit, 0x4 out-of-range report value.
module range_frame_parse_average_core
    import rfpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] op
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [21:0] distance_cm, [37:22] frame_count, zero pad
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state r_state, n_state;

    // configuration registers
    logic [DIST_W-1:0] r_limit;
    logic [DIST_W-1:0] r_report;

    // frame buffer and fill
    logic [7:0] r_buf [0:4];
    logic [2:0] r_len;

    // accumulators
    logic [SUM_W-1:0]   r_sum;
    logic [COUNT_W-1:0] r_count;
    logic               r_oor;

    // pending result
    logic [1:0]         r_res_status;
    logic [DIST_W-1:0]  r_res_dist;
    logic [COUNT_W-1:0] r_res_count;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [DIST_W-1:0]  r_out_dist;
    logic [COUNT_W-1:0] r_out_count;

    logic               cfg_wr;
    logic               do_store, do_shift, do_take, do_poll, do_emit, div_start;
    logic [7:0]         csum;
    logic               csum_ok;
    logic [RAW_W-1:0]   dist_raw;
    logic               dist_oor;
    t_div_stat          div_stat;
    logic [SUM_W-1:0]   div_q;

    assign cfg_wr = psel & penable & pwrite & pready;

    // frame fields
    assign csum     = r_buf[1] + r_buf[2] + r_buf[3];
    assign csum_ok  = (~csum == r_buf[4]);
    assign dist_raw = {r_buf[3], r_buf[2], r_buf[1]};
    assign dist_oor = (dist_raw >= {2'b00, r_limit}) || (dist_raw == INVALID_DIST);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and step controls
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        do_store      = 1'b0;
        do_shift      = 1'b0;
        do_take       = 1'b0;
        do_poll       = 1'b0;
        do_emit       = 1'b0;
        div_start     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == OP_POLL) begin
                        do_poll   = 1'b1;
                        div_start = (r_count != '0);
                        n_state   = (r_count != '0) ? ST_DIV : ST_EMIT;
                    end else begin
                        do_store = 1'b1;
                        n_state  = ST_PARSE;
                    end
                end
            end
            ST_PARSE: begin
                if (r_len == '0) begin
                    n_state = ST_IDLE;
                end else if (r_buf[0] != FRAME_HEADER) begin
                    do_shift = 1'b1;
                end else if (r_len < FRAME_LEN) begin
                    n_state = ST_IDLE;
                end else if (csum_ok) begin
                    n_state = ST_TAKE;
                end else begin
                    do_shift = 1'b1;
                end
            end
            ST_TAKE: begin
                do_take = 1'b1;
                n_state = ST_IDLE;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    do_emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= DEFAULT_LIMIT_CM;
            r_report <= DEFAULT_LIMIT_CM;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LIMIT:  r_limit  <= pwdata[DIST_W-1:0];
                REG_REPORT: r_report <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // configuration reads
    always_comb begin
        case (paddr[2])
            REG_LIMIT:  prdata = {10'd0, r_limit};
            REG_REPORT: prdata = {10'd0, r_report};
            default:    prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // buffer contents, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_buf[r_len] <= s_axis_tdata;
        end else if (do_shift) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
            r_buf[2] <= r_buf[3];
            r_buf[3] <= r_buf[4];
        end
    end

    // buffer fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (do_store) begin
            r_len <= r_len + 1'b1;
        end else if (do_shift) begin
            r_len <= r_len - 1'b1;
        end else if (do_take) begin
            r_len <= '0;
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_oor   <= 1'b0;
        end else if (do_poll) begin
            r_sum   <= '0;
            r_count <= '0;
            r_oor   <= 1'b0;
        end else if (do_take) begin
            if (dist_oor) begin
                r_oor <= 1'b1;
            end else if (r_count != COUNT_MAX) begin
                r_sum   <= r_sum + {{(SUM_W-RAW_W){1'b0}}, dist_raw};
                r_count <= r_count + 1'b1;
            end
        end
    end

    // pending result fields
    always_ff @(posedge i_clk) begin
        if (do_poll) begin
            r_res_count <= r_count;
            if (r_count != '0) begin
                r_res_status <= STATUS_AVG;
                r_res_dist   <= '0;
            end else if (r_oor) begin
                r_res_status <= STATUS_OOR;
                r_res_dist   <= r_report;
            end else begin
                r_res_status <= STATUS_NONE;
                r_res_dist   <= '0;
            end
        end else if (r_state == ST_DIV && div_stat.done) begin
            r_res_dist <= div_q[DIST_W-1:0];
        end
    end

    // average divider
    rfpa_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_out_status <= r_res_status;
            r_out_dist   <= r_res_dist;
            r_out_count  <= r_res_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {2'b00, r_out_count, r_out_dist};

`ifndef SYNTH
    // fill never passes a whole frame
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= FRAME_LEN)
        else $error("frame buffer fill above frame length");

    // a full frame never rests in the buffer between items
    a_len_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_len < FRAME_LEN))
        else $error("full frame left unparsed");

    // divider completes only while the sequencer waits on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == ST_DIV))
        else $error("divider done outside divide state");

    // poll with no averaged frames skips the divider
    a_poll_nodiv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_poll && r_count == '0) |=> (r_state == ST_EMIT && !div_stat.busy))
        else $error("empty poll started a division");

    // accumulators are clear after a poll
    a_poll_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_poll |=> (r_count == '0 && r_sum == '0 && !r_oor))
        else $error("accumulators not cleared by poll");
`endif

endmodule

// ===== verif/rfpa_reading_checker.sv =====
// reading checker: predicts poll results from observed transactions and compares them
`timescale 1ns / 1ps

module rfpa_reading_checker
    import rfpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream, watched only
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] op
    // output stream, watched only
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // [21:0] distance_cm, [37:22] frame_count, zero pad
    input  logic [1:0]  m_axis_tuser,   // [1:0] status
    // configuration port, watched only
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_pending,
    output int          o_errors
);

    typedef struct packed {
        logic [1:0]         status;
        logic [DIST_W-1:0]  distance_cm;
        logic [COUNT_W-1:0] frame_count;
    } t_reading;

    t_reading expected_readings[$];

    // parser window and accumulators
    logic [7:0]         win [5];
    int                 held_len = 0;
    logic [SUM_W-1:0]   dist_sum = '0;
    logic [COUNT_W-1:0] frame_cnt = '0;
    logic               oor_seen = 1'b0;
    logic [DIST_W-1:0]  limit_cm = DEFAULT_LIMIT_CM;
    logic [DIST_W-1:0]  report_cm = DEFAULT_LIMIT_CM;
    int                 errors = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // drop bytes up to the next held header, or empty the window
    task automatic realign();
        int found;
        found = 0;
        for (int i = 1; i < held_len && found == 0; i++) begin
            if (win[i] == FRAME_HEADER) found = i;
        end
        if (found != 0) begin
            for (int k = 0; k < held_len - found; k++) win[k] = win[k + found];
            held_len = held_len - found;
        end else begin
            held_len = 0;
        end
    endtask

    // classify one good frame
    task automatic take_frame();
        logic [RAW_W-1:0] raw;
        raw = {win[3], win[2], win[1]};
        if (raw >= {2'b00, limit_cm} || raw == INVALID_DIST) begin
            oor_seen = 1'b1;
        end else if (frame_cnt != COUNT_MAX) begin
            dist_sum = dist_sum + SUM_W'(raw);
            frame_cnt = frame_cnt + 1'b1;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        logic [7:0] csum;
        win[held_len] = b;
        held_len++;
        while (held_len > 0) begin
            if (win[0] != FRAME_HEADER) begin
                realign();
            end else if (held_len < FRAME_LEN) begin
                break;
            end else begin
                csum = win[1] + win[2] + win[3];
                if (~csum == win[4]) begin
                    take_frame();
                    held_len = 0;
                end else begin
                    realign();
                end
            end
        end
    endtask

    // expected reading for a poll, then clear accumulators
    task automatic poll_reading();
        t_reading r;
        logic [SUM_W-1:0] quotient;
        if (frame_cnt != 0) begin
            quotient = dist_sum / SUM_W'(frame_cnt);
            r.status = STATUS_AVG;
            r.distance_cm = quotient[DIST_W-1:0];
            r.frame_count = frame_cnt;
        end else if (oor_seen) begin
            r.status = STATUS_OOR;
            r.distance_cm = report_cm;
            r.frame_count = '0;
        end else begin
            r.status = STATUS_NONE;
            r.distance_cm = '0;
            r.frame_count = '0;
        end
        expected_readings.push_back(r);
        dist_sum = '0;
        frame_cnt = '0;
        oor_seen = 1'b0;
    endtask

    // watch all three ports at each edge
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_LIMIT) limit_cm = pwdata[DIST_W-1:0];
                else report_cm = pwdata[DIST_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == OP_BYTE) absorb_byte(s_axis_tdata);
                else poll_reading();
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status=%0d tdata=%h",
                                              m_axis_tuser, m_axis_tdata));
                end else begin
                    want = expected_readings.pop_front();
                    if (m_axis_tuser != want.status
                            || m_axis_tdata[21:0] != want.distance_cm
                            || m_axis_tdata[37:22] != want.frame_count
                            || m_axis_tdata[39:38] != 2'b00) begin
                        report_mismatch($sformatf(
                            "got status=%0d dist=%0d count=%0d pad=%0d, want %0d %0d %0d",
                            m_axis_tuser, m_axis_tdata[21:0], m_axis_tdata[37:22],
                            m_axis_tdata[39:38], want.status, want.distance_cm,
                            want.frame_count));
                    end
                end
            end
        end
        o_pending <= expected_readings.size();
        o_errors <= errors;
    end

endmodule

// ===== verif/tb_top.sv =====
// testbench top: stimulus, idling and verdict for the range frame parser and averager
`timescale 1ns / 1ps

module tb_top;
    import rfpa_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = OP_BYTE; // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [21:0] distance_cm, [37:22] frame_count, zero pad
    logic [1:0]  m_axis_tuser;           // [1:0] status
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int                readings_pending;
    int                mismatch_count;
    bit                quiet = 1'b0;
    logic [DIST_W-1:0] cur_limit = DEFAULT_LIMIT_CM;

    range_frame_parse_average_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    rfpa_reading_checker readings_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_pending(readings_pending), .o_errors(mismatch_count)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #100_000_000;
        $display("[range_frame_parse_average_core] ERROR");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // receiver ready with random stalls
    initial begin
        int stall;
        forever begin
            if (quiet) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                stall = pick_gap();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // one input transaction, then an optional gap
    task automatic send_item(input logic op, input logic [7:0] data);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // frame with the checksum xored by flip (zero gives a good frame)
    task automatic send_frame(input logic [RAW_W-1:0] d, input logic [7:0] flip);
        logic [7:0] s;
        s = d[7:0] + d[15:8] + d[23:16];
        send_item(OP_BYTE, FRAME_HEADER);
        send_item(OP_BYTE, d[7:0]);
        send_item(OP_BYTE, d[15:8]);
        send_item(OP_BYTE, d[23:16]);
        send_item(OP_BYTE, ~s ^ flip);
    endtask

    // stop sending until every expected result has come, then let the block settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (readings_pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [DIST_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {10'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_LIMIT) cur_limit = val;
    endtask

    // distances around the limit, the invalid marker and above 22 bits
    function automatic logic [RAW_W-1:0] pick_distance();
        int unsigned top_val;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return (cur_limit == 0) ? '0 : RAW_W'(cur_limit) - 1'b1;
            2: return RAW_W'(cur_limit);
            3: return INVALID_DIST;
            4: return RAW_W'($urandom_range(24'h400000, 24'hFFFFFF));
            default: begin
                top_val = (cur_limit == 0) ? 1000 : cur_limit + cur_limit / 8;
                return RAW_W'($urandom_range(0, top_val));
            end
        endcase
    endfunction

    // mostly good frames with random content and polls, the rest noise and broken frames
    task automatic run_random(input int n_items, input bit pause_midway);
        int sent;
        int r;
        int k;
        bit paused;
        sent = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 68) begin
                send_frame(pick_distance(), 8'h00);
                sent += 5;
                if ($urandom_range(0, 9) < 3) begin
                    send_item(OP_POLL, 8'($urandom));
                    sent++;
                end
            end else if (r < 78) begin
                send_frame(pick_distance(), 8'($urandom_range(1, 255)));
                sent += 5;
            end else if (r < 86) begin
                k = $urandom_range(1, 3);
                repeat (k) send_item(OP_BYTE, 8'($urandom));
                sent += k;
            end else if (r < 92) begin
                k = $urandom_range(1, 3);
                send_item(OP_BYTE, FRAME_HEADER);
                repeat (k) send_item(OP_BYTE, 8'($urandom));
                sent += k + 1;
            end else begin
                send_item(OP_POLL, 8'($urandom));
                sent++;
            end
            if (pause_midway && !paused && sent >= n_items / 2) begin
                paused = 1'b1;
                drain_results();
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty poll, limit edges, resync on held header, poll mid-frame
        send_item(OP_POLL, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_frame(RAW_W'(DEFAULT_LIMIT_CM) - 1'b1, 8'h00);
        send_item(OP_POLL, 8'h00);
        send_frame(RAW_W'(DEFAULT_LIMIT_CM), 8'h00);
        send_item(OP_POLL, 8'h00);
        send_item(OP_BYTE, FRAME_HEADER);
        send_item(OP_BYTE, FRAME_HEADER);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_POLL, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFE);
        send_item(OP_POLL, 8'h00);
        drain_results();

        // everything out of range, report at maximum
        cfg_write(REG_LIMIT, '0);
        cfg_write(REG_REPORT, '1);
        run_random(150, 1'b0);
        drain_results();

        // widest limit, report zero, with a pause until all results are in
        cfg_write(REG_LIMIT, '1);
        cfg_write(REG_REPORT, '0);
        run_random(250, 1'b1);
        drain_results();

        // random settings, no idling on either side
        quiet = 1'b1;
        cfg_write(REG_LIMIT, DIST_W'($urandom_range(1, 22'h3FFFFF)));
        cfg_write(REG_REPORT, DIST_W'($urandom));
        run_random(200, 1'b0);
        drain_results();
        quiet = 1'b0;

        // default limit, random report value
        cfg_write(REG_LIMIT, DEFAULT_LIMIT_CM);
        cfg_write(REG_REPORT, DIST_W'($urandom));
        run_random(200, 1'b0);
        drain_results();

        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && readings_pending == 0) begin
            $display("[range_frame_parse_average_core] OK");
        end else begin
            $display("[range_frame_parse_average_core] ERROR");
        end
        $finish;
    end

endmodule
